### sv/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg: polyline resampler shared definitions
// Default sizes, register width and reset value used by the interfaces,
// the top level and the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

  localparam int PRS_MAX_SAMPLES = 63;
  localparam int PRS_COORD_WIDTH = 32;
  localparam int PRS_RES_WIDTH   = 31;

  localparam logic [PRS_RES_WIDTH-1:0] PRS_RES_RESET = PRS_RES_WIDTH'(65536);

endpackage

`default_nettype wire

### sv/prs_if.sv
// ----------------------------------------------------------------------------
// prs_if: point stream interfaces
// Input point channel and result point channel, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface prs_in_if
  import prs_pkg::*;
#(
  parameter int COORD_WIDTH = PRS_COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;
  logic                          path_start;

  modport source (output valid, in_x, in_y, in_z, path_start, input ready);
  modport sink   (input valid, in_x, in_y, in_z, path_start, output ready);
endinterface

interface prs_out_if
  import prs_pkg::*;
#(
  parameter int COORD_WIDTH = PRS_COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          is_input_point;
  logic                          last_of_run;
  logic                          count_capped;

  modport source (output valid, out_x, out_y, out_z, is_input_point, last_of_run,
                  count_capped, input ready);
  modport sink   (input valid, out_x, out_y, out_z, is_input_point, last_of_run,
                  count_capped, output ready);
endinterface

`default_nettype wire

### sv/prs_sq_unit.sv
// ----------------------------------------------------------------------------
// prs_sq_unit: serial squaring unit
// Shift-and-add square of an unsigned operand, one multiplier bit per cycle,
// finishing early once the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_sq_unit
  import prs_pkg::*;
#(
  parameter int OPW = PRS_COORD_WIDTH + 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [OPW-1:0]   opnd,
  output logic                  busy,
  output logic [2*OPW-1:0]      prod
);

  logic [2*OPW-1:0] mcand;
  logic [OPW-1:0]   mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      mplier <= '0;
    end else if (start) begin
      mplier <= opnd;
    end else if (mplier != '0) begin
      mplier <= mplier >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= (2*OPW)'(opnd);
      prod  <= '0;
    end else if (mplier != '0) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand <= mcand << 1;
    end
  end

  assign busy = (mplier != '0);

endmodule

`default_nettype wire

### sv/prs_div_unit.sv
// ----------------------------------------------------------------------------
// prs_div_unit: serial restoring divider
// Unsigned quotient and remainder of a wide numerator by a narrow nonzero
// divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_div_unit
  import prs_pkg::*;
#(
  parameter int NW = PRS_COORD_WIDTH + 1,
  parameter int DW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quo,
  output logic [DW-1:0]      rem
);

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   dreg;
  logic [DW:0]     trial;
  logic            fits;

  assign trial = {rem, quo[NW-1]};
  assign fits  = (trial >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNTW'(NW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= num;
      rem  <= '0;
      dreg <= den;
    end else if (cnt != '0) begin
      // remainder stays below the divisor, so the trial fits one extra bit
      rem <= fits ? DW'(trial - {1'b0, dreg}) : trial[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

  assign busy = (cnt != '0);

endmodule

`default_nettype wire

### sv/polyline_resampler_top.sv
// ----------------------------------------------------------------------------
// polyline_resampler_top: uniform resampling of a 3D polyline
// Inserts evenly spaced points between consecutive input points so that the
// spacing does not exceed the programmed resolution unless the run is capped.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake            | payload
//  ----------+-----+----------------------+----------------------------------
//  in_pt     | in  | valid/ready          | in_x, in_y, in_z, path_start
//  out_pt    | out | valid/ready          | out_x, out_y, out_z, is_input_point,
//            |     |                      | last_of_run, count_capped
//  cfg       | in  | cfg_wr_en, no stall  | cfg_wr_data: resolution
//
//  a first point of a path goes straight to the output; a later point
//  squares each delta and the resolution serially, then searches the number
//  n of inserted samples (one add-compare per search step), then divides
//  each delta by n+1 unless n = 0, and emits the samples and the input point
//  in_pt.ready is high only while no point is in work
//  out_pt stalls hold the result register and pause the sample sequencer
//  synchronous reset; resolution returns to 1.0, no previous point is held
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_resampler_top
  import prs_pkg::*;
#(
  parameter int MAX_SAMPLES = PRS_MAX_SAMPLES,
  parameter int COORD_WIDTH = PRS_COORD_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  prs_in_if.sink                        in_pt,
  prs_out_if.source                     out_pt,
  input  wire logic                     cfg_wr_en,
  input  wire logic [PRS_RES_WIDTH-1:0] cfg_wr_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int DWD  = CW + 1;
  localparam int OPW  = (DWD > PRS_RES_WIDTH) ? DWD : PRS_RES_WIDTH;
  localparam int LW   = 2 * OPW + 2;
  localparam int MW   = $clog2(MAX_SAMPLES + 2);
  localparam int SW   = 2 * PRS_RES_WIDTH + 2 * MW;
  localparam int WW   = ((LW > SW) ? LW : SW) + 1;
  localparam int NAX  = 3;
  localparam logic [MW-1:0] NMAX = MW'(MAX_SAMPLES);
  localparam logic [1:0]    LAST_AX = 2'(NAX - 1);
  localparam logic [2:0]    RES_OP  = 3'(NAX);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_SR_INIT,
    ST_SEARCH,
    ST_DV_GO,
    ST_DV_WAIT,
    ST_EM_STEP,
    ST_EM_PUT,
    ST_FIN_PUT
  } state_t;

  state_t state;

  logic [PRS_RES_WIDTH-1:0] res;

  logic [CW-1:0]         prev [NAX];
  logic [CW-1:0]         cur  [NAX];
  logic [DWD-1:0]        d    [NAX];
  logic [DWD-1:0]        q0   [NAX];
  logic [MW-1:0]         r0   [NAX];
  logic [DWD-1:0]        qa   [NAX];
  logic [MW-1:0]         ra   [NAX];
  logic                  have_prev;

  logic [WW-1:0] len2;
  logic [WW-1:0] r2;
  logic [WW-1:0] s_acc;
  logic [WW-1:0] t_acc;
  logic [MW-1:0] n;
  logic [MW-1:0] m;
  logic [MW-1:0] j;
  logic [2:0]    op_idx;
  logic [1:0]    ax;
  logic          cap;

  logic            out_vld;
  logic [CW-1:0]   ox;
  logic [CW-1:0]   oy;
  logic [CW-1:0]   oz;
  logic            o_inp;
  logic            o_last;
  logic            o_cap;

  // lane helpers
  logic [DWD-1:0] mag_d   [NAX];
  logic [DWD-1:0] qa_next [NAX];
  logic [MW-1:0]  ra_next [NAX];
  logic [CW-1:0]  samp    [NAX];
  logic [MW:0]    rs      [NAX];
  logic           ge      [NAX];
  logic [DWD-1:0] qs      [NAX];

  logic             sq_start;
  logic [OPW-1:0]   sq_opnd;
  logic             sq_busy;
  logic [2*OPW-1:0] sq_prod;

  logic             dv_start;
  logic [DWD-1:0]   dv_num;
  logic             dv_busy;
  logic [DWD-1:0]   dv_quo;
  logic [MW-1:0]    dv_rem;

  logic          accept;
  logic          slot_free;
  logic          hit;
  logic [MW-1:0] n_eff;

  assign in_pt.ready = (state == ST_IDLE);
  assign accept      = in_pt.valid && in_pt.ready;
  assign slot_free   = !out_vld || out_pt.ready;

  always_comb begin
    for (int c = 0; c < NAX; c++) begin
      mag_d[c]   = d[c][DWD-1] ? (~d[c] + 1'b1) : d[c];
      rs[c]      = {1'b0, ra[c]} + {1'b0, r0[c]};
      ge[c]      = (rs[c] >= {1'b0, m});
      ra_next[c] = ge[c] ? MW'(rs[c] - {1'b0, m}) : rs[c][MW-1:0];
      qa_next[c] = qa[c] + q0[c] + DWD'(ge[c]);
      // truncation toward zero: the quotient of the magnitude takes the sign
      qs[c]      = d[c][DWD-1] ? (~qa[c] + 1'b1) : qa[c];
      samp[c]    = CW'({prev[c][CW-1], prev[c]} + qs[c]);
    end
  end

  always_comb begin
    case (op_idx)
      3'd0:    sq_opnd = OPW'(mag_d[0]);
      3'd1:    sq_opnd = OPW'(mag_d[1]);
      3'd2:    sq_opnd = OPW'(mag_d[2]);
      default: sq_opnd = OPW'(res);
    endcase
  end

  assign sq_start = (state == ST_SQ_GO);
  assign dv_start = (state == ST_DV_GO);
  assign dv_num   = mag_d[ax];

  assign hit   = (s_acc <= len2) && (n <= NMAX);
  assign n_eff = (n > NMAX) ? NMAX : n;

  prs_sq_unit #(
    .OPW (OPW)
  ) u_sq (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .opnd  (sq_opnd),
    .busy  (sq_busy),
    .prod  (sq_prod)
  );

  prs_div_unit #(
    .NW (DWD),
    .DW (MW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (m),
    .busy  (dv_busy),
    .quo   (dv_quo),
    .rem   (dv_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= PRS_RES_RESET;
    end else if (cfg_wr_en) begin
      res <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_vld   <= 1'b0;
      have_prev <= 1'b0;
      for (int c = 0; c < NAX; c++) begin
        prev[c] <= '0;
      end
    end else begin
      // the put states reload the result register on their own
      if (out_vld && out_pt.ready && (state != ST_EM_PUT) && (state != ST_FIN_PUT)) begin
        out_vld <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur[0] <= in_pt.in_x;
            cur[1] <= in_pt.in_y;
            cur[2] <= in_pt.in_z;
            d[0]   <= {in_pt.in_x[CW-1], in_pt.in_x} - {prev[0][CW-1], prev[0]};
            d[1]   <= {in_pt.in_y[CW-1], in_pt.in_y} - {prev[1][CW-1], prev[1]};
            d[2]   <= {in_pt.in_z[CW-1], in_pt.in_z} - {prev[2][CW-1], prev[2]};
            len2   <= '0;
            op_idx <= '0;
            cap    <= 1'b0;
            if (in_pt.path_start || !have_prev) begin
              state <= ST_FIN_PUT;
            end else begin
              state <= ST_SQ_GO;
            end
          end
        end
        ST_SQ_GO: begin
          state <= ST_SQ_WAIT;
        end
        ST_SQ_WAIT: begin
          if (!sq_busy) begin
            if (op_idx == RES_OP) begin
              r2    <= WW'(sq_prod);
              state <= ST_SR_INIT;
            end else begin
              len2   <= len2 + WW'(sq_prod);
              op_idx <= op_idx + 1'b1;
              state  <= ST_SQ_GO;
            end
          end
        end
        ST_SR_INIT: begin
          // s_acc holds ((n+1)*res)^2, t_acc the step to the next square
          s_acc <= r2;
          t_acc <= r2 + (r2 << 1);
          n     <= '0;
          state <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (hit) begin
            n     <= n + 1'b1;
            s_acc <= s_acc + t_acc;
            t_acc <= t_acc + (r2 << 1);
          end else begin
            cap <= (n > NMAX);
            n   <= n_eff;
            m   <= n_eff + 1'b1;
            ax  <= '0;
            if (n_eff == '0) begin
              state <= ST_FIN_PUT;
            end else begin
              state <= ST_DV_GO;
            end
          end
        end
        ST_DV_GO: begin
          state <= ST_DV_WAIT;
        end
        ST_DV_WAIT: begin
          if (!dv_busy) begin
            q0[ax] <= dv_quo;
            r0[ax] <= dv_rem;
            if (ax == LAST_AX) begin
              for (int c = 0; c < NAX; c++) begin
                qa[c] <= '0;
                ra[c] <= '0;
              end
              j     <= '0;
              state <= ST_EM_STEP;
            end else begin
              ax    <= ax + 1'b1;
              state <= ST_DV_GO;
            end
          end
        end
        ST_EM_STEP: begin
          for (int c = 0; c < NAX; c++) begin
            qa[c] <= qa_next[c];
            ra[c] <= ra_next[c];
          end
          j     <= j + 1'b1;
          state <= ST_EM_PUT;
        end
        ST_EM_PUT: begin
          if (slot_free) begin
            out_vld <= 1'b1;
            ox      <= samp[0];
            oy      <= samp[1];
            oz      <= samp[2];
            o_inp   <= 1'b0;
            o_last  <= 1'b0;
            o_cap   <= cap;
            state   <= (j == n) ? ST_FIN_PUT : ST_EM_STEP;
          end
        end
        ST_FIN_PUT: begin
          if (slot_free) begin
            out_vld   <= 1'b1;
            ox        <= cur[0];
            oy        <= cur[1];
            oz        <= cur[2];
            o_inp     <= 1'b1;
            o_last    <= 1'b1;
            o_cap     <= cap;
            prev[0]   <= cur[0];
            prev[1]   <= cur[1];
            prev[2]   <= cur[2];
            have_prev <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_pt.valid          = out_vld;
  assign out_pt.out_x          = ox;
  assign out_pt.out_y          = oy;
  assign out_pt.out_z          = oz;
  assign out_pt.is_input_point = o_inp;
  assign out_pt.last_of_run    = o_last;
  assign out_pt.count_capped   = o_cap;

endmodule

`default_nettype wire

### sv/prs_checker.sv
// ----------------------------------------------------------------------------
// prs_checker: port-level checks for the polyline resampler
// Watches the point channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_checker
  import prs_pkg::*;
#(
  parameter int COORD_WIDTH = PRS_COORD_WIDTH
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [COORD_WIDTH-1:0] out_x,
  input wire logic [COORD_WIDTH-1:0] out_y,
  input wire logic [COORD_WIDTH-1:0] out_z,
  input wire logic                   is_input_point,
  input wire logic                   last_of_run,
  input wire logic                   count_capped
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_z) && $stable(is_input_point) && $stable(last_of_run) &&
      $stable(count_capped))
    else $error("result changed while stalled");

  // one point in work at a time
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a point is in work");

  // the input point itself always closes its run
  a_last_is_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_input_point == last_of_run))
    else $error("run closed on an inserted sample");

  // inserted samples only appear while the run is still open
  a_sample_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_input_point |-> !in_ready)
    else $error("inserted sample shown while idle");

endmodule

bind polyline_resampler_top prs_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_prs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_pt.valid),
  .in_ready       (in_pt.ready),
  .out_valid      (out_pt.valid),
  .out_ready      (out_pt.ready),
  .out_x          (out_pt.out_x),
  .out_y          (out_pt.out_y),
  .out_z          (out_pt.out_z),
  .is_input_point (out_pt.is_input_point),
  .last_of_run    (out_pt.last_of_run),
  .count_capped   (out_pt.count_capped)
);

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: polyline resampler block-level test
// Drives polyline points through the input stream and checks every resampled
// point against an in-bench prediction of the uniform resampling, under
// random source gaps and sink stalls and several resolution settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import prs_pkg::*;

  localparam int CW         = PRS_COORD_WIDTH;
  localparam int STALL_MAX  = 18;
  localparam int IDLE_LIMIT = 5000;
  localparam int END_CYCLES = 60;
  localparam int PRINT_MAX  = 50;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    bit     is_input;
    bit     last;
    bit     capped;
  } sample_pt_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_wr_en;
  logic [PRS_RES_WIDTH-1:0] cfg_wr_data;

  prs_in_if  #(.COORD_WIDTH(CW)) in_pt ();
  prs_out_if #(.COORD_WIDTH(CW)) out_pt ();

  polyline_resampler_top #(
    .MAX_SAMPLES(PRS_MAX_SAMPLES),
    .COORD_WIDTH(CW)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_pt      (in_pt),
    .out_pt     (out_pt),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // predicted state of the block
  coord_t                   last_x;
  coord_t                   last_y;
  coord_t                   last_z;
  bit                       holds_point;
  logic [PRS_RES_WIDTH-1:0] cur_res;

  sample_pt_t pending_points[$];

  int  error_count;
  int  points_sent;
  int  samples_checked;
  int  capped_runs;
  int  res_settings;
  int  idle_cycles;
  bit  idle_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait();
    if (idle_off) return 0;
    return $urandom_range(0, STALL_MAX);
  endfunction

  function automatic void flag_error(string what, longint want, longint got);
    error_count++;
    if (error_count <= PRINT_MAX)
      $display("%0t %s mismatch: expected %h, got %h", $time, what, want, got);
  endfunction

  // expected samples for one accepted point, in output order
  task automatic predict_samples(input coord_t x, input coord_t y, input coord_t z,
                                 input bit start);
    longint     dx, dy, dz, ax, ay, az, div;
    logic [79:0] ux, uy, uz, len2, step;
    int         n;
    bit         cap;
    sample_pt_t pt;
    if (start || !holds_point) begin
      pt = '{x: x, y: y, z: z, is_input: 1'b1, last: 1'b1, capped: 1'b0};
      pending_points = {pending_points, pt};
    end else begin
      dx = longint'(x) - longint'(last_x);
      dy = longint'(y) - longint'(last_y);
      dz = longint'(z) - longint'(last_z);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      az = dz < 0 ? -dz : dz;
      ux = ax;
      uy = ay;
      uz = az;
      len2 = ux * ux + uy * uy + uz * uz;
      n = 0;
      while (n <= PRS_MAX_SAMPLES) begin
        step = 80'(n + 1) * 80'(cur_res);
        if (step * step > len2) break;
        n++;
      end
      cap = 1'b0;
      if (n > PRS_MAX_SAMPLES) begin
        n = PRS_MAX_SAMPLES;
        cap = 1'b1;
        capped_runs++;
      end
      div = n + 1;
      for (int j = 1; j <= n; j++) begin
        // truncating division, as signed longint division does
        pt.x = CW'(longint'(last_x) + (dx * j) / div);
        pt.y = CW'(longint'(last_y) + (dy * j) / div);
        pt.z = CW'(longint'(last_z) + (dz * j) / div);
        pt.is_input = 1'b0;
        pt.last = 1'b0;
        pt.capped = cap;
        pending_points = {pending_points, pt};
      end
      pt = '{x: x, y: y, z: z, is_input: 1'b1, last: 1'b1, capped: cap};
      pending_points = {pending_points, pt};
    end
    last_x = x;
    last_y = y;
    last_z = z;
    holds_point = 1'b1;
  endtask

  // valid stays high after the transfer; a drain, or a next call that draws a gap, lowers it
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                            input bit start);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_pt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pt.valid      <= 1'b1;
    in_pt.in_x       <= x;
    in_pt.in_y       <= y;
    in_pt.in_z       <= z;
    in_pt.path_start <= start;
    do @(posedge clk); while (!in_pt.ready);
    points_sent++;
    predict_samples(x, y, z, start);
  endtask

  task automatic wait_drain();
    in_pt.valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic set_resolution(input logic [PRS_RES_WIDTH-1:0] value);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_res = value;
    res_settings++;
    @(posedge clk);
  endtask

  // sink side: random stall before each result
  initial begin
    int hold;
    out_pt.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_pt.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_pt.ready <= 1'b1;
      do @(posedge clk); while (!out_pt.valid);
    end
  end

  always @(posedge clk) begin : result_check
    sample_pt_t want;
    if (!rst && out_pt.valid && out_pt.ready) begin
      samples_checked++;
      if (pending_points.size() == 0) begin
        flag_error("unexpected transfer x", 0, out_pt.out_x);
      end else begin
        want = pending_points.pop_front();
        if (out_pt.out_x !== want.x) flag_error("out_x", want.x, out_pt.out_x);
        if (out_pt.out_y !== want.y) flag_error("out_y", want.y, out_pt.out_y);
        if (out_pt.out_z !== want.z) flag_error("out_z", want.z, out_pt.out_z);
        if (out_pt.is_input_point !== want.is_input)
          flag_error("is_input_point", want.is_input, out_pt.is_input_point);
        if (out_pt.last_of_run !== want.last)
          flag_error("last_of_run", want.last, out_pt.last_of_run);
        if (out_pt.count_capped !== want.capped)
          flag_error("count_capped", want.capped, out_pt.count_capped);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_pt.valid && in_pt.ready) || (out_pt.valid && out_pt.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t no transfer for %0d cycles, %0d results outstanding", $time,
                 IDLE_LIMIT, pending_points.size());
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic test_first_point();
    // no point seen since reset, then an explicit path start
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh12345678, 1'b0);
    send_point(-32'sd1, -32'sd1, -32'sd1, 1'b1);
  endtask

  task automatic test_repeated_point();
    send_point(-32'sd1, -32'sd1, -32'sd1, 1'b0);
  endtask

  task automatic test_unit_spacing();
    send_point(32'sh00038000, -32'sd1, -32'sd1, 1'b0);
    send_point(-32'sh20000, -32'sh30000, 32'sh18000, 1'b0);
    send_point(-32'sh20000 + 100, -32'sh30000, 32'sh18000, 1'b0);
  endtask

  task automatic test_count_cap();
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    // 63 steps exactly, then 64 which saturates
    send_point(0, 0, 0, 1'b1);
    send_point(32'sd63 <<< 16, 0, 0, 1'b0);
    send_point(32'sd127 <<< 16, 0, 0, 1'b0);
  endtask

  task automatic test_resolution_extremes();
    set_resolution(31'h7fffffff);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    set_resolution(31'd1);
    send_point(0, 0, 0, 1'b1);
    send_point(0, 5, 0, 1'b0);
    send_point(0, 5, -3, 1'b0);
    // zero resolution saturates even on a repeated point
    set_resolution(31'd0);
    send_point(1, 1, 1, 1'b0);
    send_point(1, 1, 1, 1'b0);
    send_point(32'sh40000000, -32'sh40000000, 7, 1'b1);
  endtask

  function automatic longint pick_delta(longint span);
    longint unsigned r;
    if (span == 0 || $urandom_range(0, 2) == 0) return 0;
    r = {$urandom, $urandom};
    r = r % longint'(span + 1);
    return $urandom_range(0, 1) ? -longint'(r) : longint'(r);
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return CW'(v);
  endfunction

  // mostly paths with spacing near the resolution, some noise and restarts
  task automatic test_random_paths(input logic [PRS_RES_WIDTH-1:0] res, input int count);
    longint span;
    coord_t x, y, z;
    set_resolution(res);
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) idle_off = ($urandom_range(0, 3) == 0);
      if (i == count / 2) wait_drain();
      if ($urandom_range(0, 9) == 0) begin
        send_point($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end else if (!holds_point || $urandom_range(0, 15) == 0) begin
        send_point($urandom, $urandom, $urandom, 1'b1);
      end else begin
        span = longint'(cur_res) * $urandom_range(0, 70);
        x = clamp_coord(longint'(last_x) + pick_delta(span));
        y = clamp_coord(longint'(last_y) + pick_delta(span));
        z = clamp_coord(longint'(last_z) + pick_delta(span));
        send_point(x, y, z, 1'b0);
      end
    end
    idle_off = 1'b0;
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_pt.valid      <= 1'b0;
    in_pt.in_x       <= '0;
    in_pt.in_y       <= '0;
    in_pt.in_z       <= '0;
    in_pt.path_start <= 1'b0;
    last_x = '0;
    last_y = '0;
    last_z = '0;
    holds_point = 1'b0;
    cur_res = PRS_RES_RESET;
    idle_off = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_point();
    test_repeated_point();
    test_unit_spacing();
    test_count_cap();
    test_resolution_extremes();

    test_random_paths(31'd65536, 64);
    test_random_paths(31'd1, 64);
    test_random_paths(PRS_RES_WIDTH'($urandom_range(1 << 12, 1 << 22)), 64);
    test_random_paths(31'h7fffffff, 64);
    test_random_paths(PRS_RES_WIDTH'($urandom_range(1, 32'h7fffffff)), 64);

    wait_drain();
    repeat (END_CYCLES) @(posedge clk);

    $display("covered %0d input points and %0d resampled points, %0d runs capped,",
             points_sent, samples_checked, capped_runs);
    $display("across %0d resolution settings including zero and full scale",
             res_settings);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
